// File: rtl/modexp_pkg.sv
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

	// register index of the modulus
	localparam int unsigned REG_MODULUS = 0;

	// modulus after reset, cut to the datapath width where it is used
	localparam logic [63:0] RESET_MODULUS = 64'd453371;

endpackage

// File: rtl/modexp_mulmod.sv
// ----------------------------------------------------------------------------
// modexp_mulmod
// Bit-serial modular multiplier: r = a * b mod m, one bit of b per cycle,
// most significant first. Needs a < m.
// ----------------------------------------------------------------------------
module modexp_mulmod #(
	parameter int WIDTH = 31
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	input  logic [WIDTH-1:0] m,
	output logic             done,
	output logic [WIDTH-1:0] r
);

	localparam int CW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] b_q;
	logic [WIDTH-1:0] r_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [WIDTH:0]   dbl;
	logic [WIDTH:0]   dbl_red;
	logic [WIDTH:0]   sum;
	logic [WIDTH:0]   sum_red;
	logic [WIDTH-1:0] r_next;

	// r <- 2r mod m, then + a mod m when the bit is set
	always_comb begin
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= {1'b0, m}) ? (dbl - {1'b0, m}) : dbl;
		sum     = dbl_red + {1'b0, a_q};
		sum_red = (sum >= {1'b0, m}) ? (sum - {1'b0, m}) : sum;
		r_next  = b_q[WIDTH-1] ? sum_red[WIDTH-1:0] : dbl_red[WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q    <= a;
				b_q    <= b;
				r_q    <= '0;
				cnt_q  <= CW'(WIDTH);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				r_q   <= r_next;
				b_q   <= {b_q[WIDTH-2:0], 1'b0};
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign r    = r_q;

endmodule

// File: rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// base ^ exponent mod modulus by right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// Sequence: the base is first reduced mod the modulus, then for each exponent
// bit up to the top set bit one square, plus one multiply when the bit is set.
// One request at a time: a new one is taken only once the last result is registered.
// Reset: modulus returns to 453371, no result pending, ready for a request.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
	parameter int WIDTH = 31
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [((WIDTH > 32) ? 4 : 3)-1:0]   paddr,
	input  logic [((WIDTH > 32) ? 64 : 32)-1:0] pwdata,
	output logic [((WIDTH > 32) ? 64 : 32)-1:0] prdata,
	output logic                                pready,
	// request
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [WIDTH-1:0]                    base,
	input  logic [WIDTH-1:0]                    exponent,
	// result
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [WIDTH-1:0]                    power_mod
);

	localparam int DATA_W   = (WIDTH > 32) ? 64 : 32;
	localparam int ADDR_W   = (WIDTH > 32) ? 4 : 3;
	localparam int ADDR_LSB = ADDR_W - 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RED,
		S_BIT,
		S_MUL,
		S_SQR,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [WIDTH-1:0] modulus_q;
	logic [WIDTH-1:0] e_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] sq_q;
	logic [WIDTH-1:0] mul_a_q;
	logic [WIDTH-1:0] mul_b_q;
	logic             mul_start_q;
	logic [WIDTH-1:0] power_mod_q;
	logic             out_valid_q;

	logic             mul_done;
	logic [WIDTH-1:0] mul_r;
	logic             reg_hit;

	// configuration port
	assign pready  = 1'b1;
	assign reg_hit = (paddr[ADDR_W-1:ADDR_LSB] == 1'(modexp_pkg::REG_MODULUS));
	assign prdata  = reg_hit ? DATA_W'(modulus_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= modexp_pkg::RESET_MODULUS[WIDTH-1:0];
		end else if (psel && penable && pwrite && reg_hit) begin
			modulus_q <= pwdata[WIDTH-1:0];
		end
	end

	modexp_mulmod #(
		.WIDTH (WIDTH)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.m      (modulus_q),
		.done   (mul_done),
		.r      (mul_r)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign power_mod = power_mod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mul_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mul_start_q <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						e_q <= exponent;
						if (modulus_q < WIDTH'(2)) begin
							acc_q   <= '0;
							state_q <= S_DONE;
						end else begin
							// base mod m as 1 * base mod m
							mul_a_q     <= WIDTH'(1);
							mul_b_q     <= base;
							mul_start_q <= 1'b1;
							state_q     <= S_RED;
						end
					end
				end
				S_RED: begin
					if (mul_done) begin
						sq_q    <= mul_r;
						acc_q   <= WIDTH'(1);
						state_q <= S_BIT;
					end
				end
				S_BIT: begin
					if (e_q == '0) begin
						state_q <= S_DONE;
					end else if (e_q[0]) begin
						mul_a_q     <= acc_q;
						mul_b_q     <= sq_q;
						mul_start_q <= 1'b1;
						state_q     <= S_MUL;
					end else begin
						mul_a_q     <= sq_q;
						mul_b_q     <= sq_q;
						mul_start_q <= 1'b1;
						state_q     <= S_SQR;
					end
				end
				S_MUL: begin
					if (mul_done) begin
						acc_q       <= mul_r;
						mul_a_q     <= sq_q;
						mul_b_q     <= sq_q;
						mul_start_q <= 1'b1;
						state_q     <= S_SQR;
					end
				end
				S_SQR: begin
					if (mul_done) begin
						sq_q    <= mul_r;
						e_q     <= {1'b0, e_q[WIDTH-1:1]};
						state_q <= S_BIT;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						power_mod_q <= acc_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: tb/modular_exponentiation_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modular_exponentiation_tb
// Self-checking bench for base ^ exponent mod modulus.
// Directed corner requests are sent first, then random requests under ten
// modulus settings. Among these settings are modulus one, modulus zero, the
// largest modulus, and writes that set the top bit of the data word. A
// scoreboard computes each expected residue with exact 64-bit products and
// checks results in order. Both handshakes idle at random in most phases.
// ----------------------------------------------------------------------------
module modular_exponentiation_tb;

	localparam int W = 31;
	localparam int AW = (W > 32) ? 4 : 3;
	localparam int DW = (W > 32) ? 64 : 32;
	localparam int unsigned REG_STRIDE = (W > 32) ? 8 : 4;
	localparam int unsigned REG_UNUSED = modexp_pkg::REG_MODULUS + 1;
	localparam int PHASES = 10;
	localparam int PHASE_REQUESTS = 28;
	localparam int MAX_IDLE = 17;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES = 2 * W * (W + 3) + 100;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int REPORT_MAX = 10;

	class power_scoreboard;
		logic [W-1:0] modulus;
		logic [W-1:0] power_expect_q[$];
		int failures;
		int checked;
		int requests;

		function new();
			modulus = modexp_pkg::RESET_MODULUS[W-1:0];
			failures = 0;
			checked = 0;
			requests = 0;
		endfunction

		function void write_register(int unsigned index, logic [DW-1:0] value);
			if (index == modexp_pkg::REG_MODULUS) begin
				modulus = value[W-1:0];
			end
		endfunction

		// right-to-left square-and-multiply; operands stay below 2^31 so
		// every product fits in 64 bits
		function logic [W-1:0] mod_power(logic [W-1:0] b, logic [W-1:0] e);
			longint unsigned m;
			longint unsigned sq;
			longint unsigned acc;
			m = modulus;
			if (m == 0) begin
				return '0;
			end
			sq = b % m;
			acc = 1 % m;
			for (int k = 0; k < W; k++) begin
				if (e[k]) begin
					acc = (acc * sq) % m;
				end
				sq = (sq * sq) % m;
			end
			return acc[W-1:0];
		endfunction

		function void note_request(logic [W-1:0] b, logic [W-1:0] e);
			power_expect_q.push_back(mod_power(b, e));
			requests++;
		endfunction

		function void check_result(logic [W-1:0] actual);
			logic [W-1:0] want;
			if (power_expect_q.size() == 0) begin
				failures++;
				if (failures <= REPORT_MAX) begin
					$display("unexpected result power_mod=%0d", actual);
				end
				return;
			end
			want = power_expect_q.pop_front();
			checked++;
			if (actual !== want) begin
				failures++;
				if (failures <= REPORT_MAX) begin
					$display("power_mod mismatch: expected %0d, got %0d (modulus %0d)",
						want, actual, modulus);
				end
			end
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          psel = 1'b0;
	logic          penable = 1'b0;
	logic          pwrite = 1'b0;
	logic [AW-1:0] paddr = '0;
	logic [DW-1:0] pwdata = '0;
	logic [DW-1:0] prdata;
	logic          pready;
	logic          in_valid = 1'b0;
	logic          in_ready;
	logic [W-1:0]  base = '0;
	logic [W-1:0]  exponent = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	logic [W-1:0]  power_mod;

	power_scoreboard sb = new();
	bit no_idle = 1'b0;
	int cfg_writes = 0;
	int cycles = 0;

	modular_exponentiation #(
		.WIDTH(W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.base(base),
		.exponent(exponent),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.power_mod(power_mod)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic write_register(int unsigned index, logic [DW-1:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= AW'(index * REG_STRIDE);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_register(index, value);
		cfg_writes++;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_request(logic [W-1:0] b, logic [W-1:0] e);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		base <= b;
		exponent <= e;
		do @(posedge clk); while (!(in_valid && in_ready));
		sb.note_request(b, e);
	endtask

	task automatic drain_requests();
		in_valid <= 1'b0;
		while (sb.power_expect_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [W-1:0] pick_base();
		case ($urandom_range(0, 7))
			4: return W'($urandom_range(0, 15));
			5: return ($urandom_range(0, 1) != 0) ? '1 : '0;
			6: return W'(longint'(sb.modulus) * $urandom_range(1, 3));
			7: return sb.modulus - 1'b1;
			default: return W'($urandom);
		endcase
	endfunction

	// random exponent length keeps most requests short
	function automatic logic [W-1:0] pick_exponent();
		int bits;
		logic [63:0] mask;
		logic [W-1:0] e;
		bits = $urandom_range(0, W);
		if (bits == 0) begin
			return '0;
		end
		mask = (64'd1 << bits) - 64'd1;
		e = W'($urandom) & mask[W-1:0];
		e[bits-1] = 1'b1;
		return e;
	endfunction

	function automatic logic [DW-1:0] pick_modulus(int phase);
		case (phase)
			0: return DW'($urandom_range(3, 32'h7FFF_FFFF) | 1);
			1: return DW'($urandom_range(2, 64));
			2: return DW'(32'h7FFF_FFFF);
			3: return DW'(1);
			4: return DW'($urandom);
			5: return DW'(2);
			6: return DW'($urandom_range(32'h0001_0000, 32'h7FFF_FFFF));
			7: return DW'(0);
			8: return DW'($urandom_range(2, 1000));
			default: return DW'(32'hFFFF_FFFF);
		endcase
	endfunction

	initial begin
		forever begin
			int stall;
			stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			sb.check_result(power_mod);
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset modulus
		send_request('0, '0);
		send_request('0, 1);
		send_request('1, '0);
		send_request('1, '1);
		send_request(1, '1);
		send_request(2, 10);
		send_request(453371, 5);
		send_request(453372, 3);
		send_request(12345, W'(32'h4000_0000));
		drain_requests();

		write_register(modexp_pkg::REG_MODULUS, DW'(1));
		send_request('0, '0);
		send_request(5, '0);
		send_request('1, '1);
		drain_requests();

		// top data bit is dropped, leaving modulus zero
		write_register(modexp_pkg::REG_MODULUS, DW'(32'h8000_0000));
		send_request(7, 3);
		send_request('0, '0);
		drain_requests();

		write_register(modexp_pkg::REG_MODULUS, DW'(32'h7FFF_FFFF));
		send_request('1, 1);
		send_request(W'(32'h7FFF_FFFE), '1);
		send_request(2, W'(32'h7FFF_FFFE));
		drain_requests();

		write_register(REG_UNUSED, DW'(32'h0000_0005));
		send_request(3, 4);
		send_request('0, 9);
		drain_requests();

		for (int phase = 0; phase < PHASES; phase++) begin
			write_register(modexp_pkg::REG_MODULUS, pick_modulus(phase));
			if (phase == 4) begin
				write_register(REG_UNUSED, DW'($urandom));
			end
			no_idle = (phase % 3 == 2);
			repeat (PHASE_REQUESTS) begin
				send_request(pick_base(), pick_exponent());
			end
			drain_requests();
		end
		no_idle = 1'b0;

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d requests sent, %0d results checked, %0d register writes",
			sb.requests, sb.checked, cfg_writes);
		$display("moduli covered: reset value, 0, 1, 2, small, random, 2^31-1, truncated");
		if (sb.failures == 0 && sb.power_expect_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d failures, %0d results missing", sb.failures,
				sb.power_expect_q.size());
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
